// File: hdl/rms_and_max_error_compare_assert.svh
// assertion macros shared by the rms and max error compare block
`ifndef RMS_AND_MAX_ERROR_COMPARE_ASSERT_SVH
`define RMS_AND_MAX_ERROR_COMPARE_ASSERT_SVH
`ifndef ASSERT_OFF
// antecedent holds, consequent must hold in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// antecedent holds, consequent must hold in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
// condition must never hold
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: hdl/rmse_pkg.sv
// types and constants of the rms and max error compare block
package rmse_pkg;

	// defaults of the top level parameters
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int MAX_PAIRS_DEF   = 65536;

	// fixed field widths
	localparam int FIELD_W = 24;
	localparam int COUNT_W = 17;
	localparam int SUM_W   = 64;
	localparam int ROOT_W  = SUM_W / 2;

	// iteration counts of the shared divide and root sequence
	localparam int DIV_STEPS  = SUM_W;
	localparam int ROOT_STEPS = SUM_W / 2;
	localparam int STEP_CNT_W = $clog2(DIV_STEPS);
	localparam logic [STEP_CNT_W-1:0] DIV_LAST  = STEP_CNT_W'(DIV_STEPS - 1);
	localparam logic [STEP_CNT_W-1:0] ROOT_LAST = STEP_CNT_W'(ROOT_STEPS - 1);

	// one input item
	typedef struct packed {
		logic signed [FIELD_W-1:0] sample_a;
		logic signed [FIELD_W-1:0] sample_b;
		logic                      last_item;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic [FIELD_W-1:0] rms_error;
		logic [FIELD_W-1:0] max_error;
		logic [COUNT_W-1:0] pair_count;
		logic               overflow;
	} out_item_t;

	// commands from controller to datapath
	typedef struct packed {
		logic take;
		logic div_load;
		logic div_step;
		logic root_step;
		logic res_load;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic last_acc;
		logic out_free;
	} status_t;

endpackage

// File: hdl/rmse_datapath.sv
// datapath: difference pipeline, accumulators, divide and root unit, result register
`include "rms_and_max_error_compare_assert.svh"
module rmse_datapath #(
	parameter int SAMPLE_BITS = rmse_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_PAIRS   = rmse_pkg::MAX_PAIRS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rmse_pkg::in_item_t  sample,
	input  rmse_pkg::cmd_t      cmd,
	output rmse_pkg::status_t   status,
	output logic                result_valid,
	input  logic                result_stall,
	output rmse_pkg::out_item_t result
);
	import rmse_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam logic [COUNT_W-1:0] PAIRS_FULL = COUNT_W'(MAX_PAIRS);

	logic signed [SB-1:0] sa_w, sb_w;
	logic signed [SB:0]   diff_w, neg_w, absd_w;
	logic [SB-1:0]        ad_s1, ad_s2;
	logic [2*SB-1:0]      sq_s2;
	logic                 v_s1, v_s2, last_s1, last_s2;

	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W:0]     sum_ext;
	logic [FIELD_W-1:0] max_q;
	logic [COUNT_W-1:0] pairs_q;
	logic               sat_q;

	logic [SUM_W-1:0]   n_q;
	logic [COUNT_W-1:0] drem_q;
	logic [COUNT_W:0]   d_shift, d_diff;
	logic               d_ge;
	logic [ROOT_W+1:0]  srem_q;
	logic [ROOT_W+3:0]  s_shift, s_trial, s_diff;
	logic               s_ge;
	logic [ROOT_W-1:0]  root_q;
	logic [FIELD_W-1:0] root_clamp;

	logic      out_valid_q;
	out_item_t out_q;

	// absolute difference of the low sample bits
	assign sa_w   = sample.sample_a[SB-1:0];
	assign sb_w   = sample.sample_b[SB-1:0];
	assign diff_w = (SB+1)'(sa_w) - (SB+1)'(sb_w);
	assign neg_w  = -diff_w;
	assign absd_w = diff_w[SB] ? neg_w : diff_w;

	// saturating sum
	assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(sq_s2);

	// one restoring divide step
	assign d_shift = {drem_q, n_q[SUM_W-1]};
	assign d_diff  = d_shift - {1'b0, pairs_q};
	assign d_ge    = d_shift >= {1'b0, pairs_q};

	// one root digit step
	assign s_shift = {srem_q, n_q[SUM_W-1:SUM_W-2]};
	assign s_trial = {2'b00, root_q, 2'b01};
	assign s_diff  = s_shift - s_trial;
	assign s_ge    = s_shift >= s_trial;

	assign root_clamp = (root_q[ROOT_W-1:FIELD_W] != '0) ? '1 : root_q[FIELD_W-1:0];

	// pipeline valids, accumulators and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			sum_q       <= '0;
			max_q       <= '0;
			pairs_q     <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.take;
			v_s2 <= v_s1;
			if (cmd.res_load) begin
				sum_q   <= '0;
				max_q   <= '0;
				pairs_q <= '0;
				sat_q   <= 1'b0;
			end else if (v_s2) begin
				if (FIELD_W'(ad_s2) > max_q) begin
					max_q <= FIELD_W'(ad_s2);
				end
				if (sum_ext[SUM_W]) begin
					sum_q <= '1;
				end else begin
					sum_q <= sum_ext[SUM_W-1:0];
				end
				if (pairs_q >= PAIRS_FULL) begin
					pairs_q <= PAIRS_FULL;
				end else begin
					pairs_q <= pairs_q + 1'b1;
				end
				// either a full sum or a full count marks the run
				if (sum_ext[SUM_W] || (pairs_q >= PAIRS_FULL)) begin
					sat_q <= 1'b1;
				end
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload of pipeline, divide and root unit, result
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			ad_s1   <= absd_w[SB-1:0];
			last_s1 <= sample.last_item;
		end
		ad_s2   <= ad_s1;
		sq_s2   <= ad_s1 * ad_s1;
		last_s2 <= last_s1;
		if (cmd.div_load) begin
			n_q    <= sum_q;
			drem_q <= '0;
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.div_step) begin
			n_q    <= {n_q[SUM_W-2:0], d_ge};
			drem_q <= d_ge ? d_diff[COUNT_W-1:0] : d_shift[COUNT_W-1:0];
		end else if (cmd.root_step) begin
			n_q    <= {n_q[SUM_W-3:0], 2'b00};
			srem_q <= s_ge ? s_diff[ROOT_W+1:0] : s_shift[ROOT_W+1:0];
			root_q <= {root_q[ROOT_W-2:0], s_ge};
		end
		if (cmd.res_load) begin
			out_q.rms_error  <= root_clamp;
			out_q.max_error  <= max_q;
			out_q.pair_count <= pairs_q;
			out_q.overflow   <= sat_q;
		end
	end

	assign status.last_acc = v_s2 && last_s2;
	assign status.out_free = !out_valid_q || !result_stall;
	assign result_valid    = out_valid_q;
	assign result          = out_q;

	`ASSERT_NEXT(a_clear_after_load, clk, arst_n, cmd.res_load, pairs_q == '0 && sum_q == '0 && !sat_q)
	`ASSERT_NEVER(a_no_item_in_divide, clk, arst_n, v_s2 && (cmd.div_step || cmd.root_step))
	`ASSERT_IMPLIES(a_valid_from_load, clk, arst_n, $rose(out_valid_q), $past(cmd.res_load))

endmodule

// File: hdl/rmse_controller.sv
// controller: run, drain, load, divide, root and publish sequencing
`include "rms_and_max_error_compare_assert.svh"
module rmse_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  logic              sample_last,
	output logic              sample_stall,
	input  rmse_pkg::status_t status,
	output rmse_pkg::cmd_t    cmd
);
	import rmse_pkg::*;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_DRAIN,
		ST_LOAD,
		ST_DIVIDE,
		ST_ROOT,
		ST_PUBLISH
	} state_t;

	state_t                state_q;
	logic [STEP_CNT_W-1:0] cnt_q;

	// commands decoded from state
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_RUN:     cmd.take      = sample_valid;
			ST_LOAD:    cmd.div_load  = 1'b1;
			ST_DIVIDE:  cmd.div_step  = 1'b1;
			ST_ROOT:    cmd.root_step = 1'b1;
			ST_PUBLISH: cmd.res_load  = status.out_free;
			default:    cmd = '0;
		endcase
	end

	assign sample_stall = (state_q != ST_RUN);

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (sample_valid && sample_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (status.last_acc) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (cnt_q == DIV_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_ROOT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ROOT: begin
					if (cnt_q == ROOT_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_PUBLISH;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_PUBLISH: begin
					if (status.out_free) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	`ASSERT_IMPLIES(a_load_after_drain, clk, arst_n, cmd.div_load, $past(state_q) == ST_DRAIN)
	`ASSERT_NEXT(a_publish_to_run, clk, arst_n, cmd.res_load, state_q == ST_RUN)
	`ASSERT_IMPLIES(a_root_count, clk, arst_n, state_q == ST_ROOT, cnt_q <= ROOT_LAST)

endmodule

// File: hdl/rms_and_max_error_compare.sv
// Usage of the rms and max error compare block
//
// Input channel sample: each item carries sample_a, sample_b and last_item.
// Items are taken one per cycle while a run is open. Only the low
// SAMPLE_BITS bits of each sample are used, as two's complement.
// Output channel result: one item per run, after the item marked last, with
// rms_error, max_error, pair_count and overflow.
// Throughput: one pair per cycle within a run. After the last pair the input
// stalls while the two pipeline stages drain, the load step runs, a restoring
// divide of the sum by the count and a digit-by-digit root run, both on one
// shared shift unit, and the result is published.
// A finished result sits in the output register; the next run starts while
// it waits. If result_stall is still high when the following run ends, the
// block holds in its publish state and keeps the input stalled.
// Reset clears the accumulators, the pipeline and result_valid at once.
module rms_and_max_error_compare #(
	parameter int SAMPLE_BITS = rmse_pkg::SAMPLE_BITS_DEF,
	parameter int MAX_PAIRS   = rmse_pkg::MAX_PAIRS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  rmse_pkg::in_item_t  sample,
	output logic                result_valid,
	input  logic                result_stall,
	output rmse_pkg::out_item_t result
);
	import rmse_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencing
	rmse_controller u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_last  (sample.last_item),
		.sample_stall (sample_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// arithmetic and result register
	rmse_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_PAIRS   (MAX_PAIRS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
